// ===== hw/rtl/lsie_pkg.sv =====
// shared types, codes and helpers for the lattice site interface energy block
package lsie_pkg;

   localparam int unsigned DEF_MAX_WIDTH  = 64;
   localparam int unsigned DEF_MAX_HEIGHT = 64;
   localparam int unsigned DEF_SPIN_BITS  = 16;

   localparam int unsigned NBR_COUNT   = 8;
   localparam int unsigned ENERGY_BITS = 19;
   localparam int unsigned COORD_BITS  = 6;
   localparam int unsigned DIM_BITS    = 7;
   localparam int unsigned E_BITS      = 16;
   localparam int unsigned SPIN_IN_BITS = 16;

   localparam logic [DIM_BITS-1:0] RST_DIM    = 7'd64;
   localparam logic [E_BITS-1:0]   RST_ENERGY = 16'd256;

   typedef enum logic [1:0] {
      REG_WIDTH    = 2'd0,
      REG_HEIGHT   = 2'd1,
      REG_HETERO   = 2'd2,
      REG_BOUNDARY = 2'd3
   } csr_reg_type;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      AX_SAME = 2'd0,
      AX_DEC  = 2'd1,
      AX_INC  = 2'd2
   } axis_sel_type;

   typedef struct packed {
      axis_sel_type xs;
      axis_sel_type ys;
   } nbr_sel_type;

   typedef struct packed {
      logic clear;
      logic load_center;
      logic add;
   } acc_ctl_type;

   // read slot 0 is the centre, slots 1..8 the moore neighbors
   function automatic nbr_sel_type nbr_sel(input logic [3:0] slot);
      nbr_sel_type s;
      case (slot)
         4'd1:    s = '{xs: AX_INC,  ys: AX_SAME};
         4'd2:    s = '{xs: AX_INC,  ys: AX_DEC};
         4'd3:    s = '{xs: AX_SAME, ys: AX_DEC};
         4'd4:    s = '{xs: AX_DEC,  ys: AX_DEC};
         4'd5:    s = '{xs: AX_DEC,  ys: AX_SAME};
         4'd6:    s = '{xs: AX_DEC,  ys: AX_INC};
         4'd7:    s = '{xs: AX_SAME, ys: AX_INC};
         4'd8:    s = '{xs: AX_INC,  ys: AX_INC};
         default: s = '{xs: AX_SAME, ys: AX_SAME};
      endcase
      return s;
   endfunction

   // zero reads as one, large values saturate
   function automatic int unsigned clamp_dim(input logic [DIM_BITS-1:0] v,
                                             input int unsigned maxv);
      int unsigned vi;
      vi = {25'd0, v};
      if (vi == 0)
         return 1;
      else if (vi > maxv)
         return maxv;
      else
         return vi;
   endfunction

endpackage

// ===== hw/rtl/lsie_coord.sv =====
// bit-serial reduction of the site coordinates modulo the lattice size
module lsie_coord #(
   parameter int unsigned MAX_WIDTH  = lsie_pkg::DEF_MAX_WIDTH,
   parameter int unsigned MAX_HEIGHT = lsie_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic [lsie_pkg::COORD_BITS-1:0]         pos_x,
   input  logic [lsie_pkg::COORD_BITS-1:0]         pos_y,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]          dim_w,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]         dim_h,
   output logic [$clog2(MAX_WIDTH)-1:0]            site_x,
   output logic [$clog2(MAX_HEIGHT)-1:0]           site_y,
   output logic                                    done
);
   import lsie_pkg::*;

   localparam int unsigned WW  = $clog2(MAX_WIDTH+1);
   localparam int unsigned HW  = $clog2(MAX_HEIGHT+1);
   localparam int unsigned XW  = $clog2(MAX_WIDTH);
   localparam int unsigned YW  = $clog2(MAX_HEIGHT);
   localparam int unsigned CWX = WW + COORD_BITS;
   localparam int unsigned CWY = HW + COORD_BITS;

   logic [COORD_BITS-1:0] rx_ff, rx_in;
   logic [COORD_BITS-1:0] ry_ff, ry_in;
   logic [2:0]            step_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [CWX-1:0]        dvx;
   logic [CWY-1:0]        dvy;

   // restoring remainder: try divisor shifted by step, subtract if it fits
   always_comb begin
      dvx   = CWX'(dim_w) << step_ff;
      dvy   = CWY'(dim_h) << step_ff;
      rx_in = rx_ff;
      ry_in = ry_ff;
      if (CWX'(rx_ff) >= dvx) begin
         rx_in = rx_ff - dvx[COORD_BITS-1:0];
      end
      if (CWY'(ry_ff) >= dvy) begin
         ry_in = ry_ff - dvy[COORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rx_ff   <= pos_x;
            ry_ff   <= pos_y;
            step_ff <= 3'(COORD_BITS - 1);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rx_ff   <= rx_in;
            ry_ff   <= ry_in;
            step_ff <= step_ff - 3'd1;
            if (step_ff == 3'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign site_x = XW'(rx_ff);
   assign site_y = YW'(ry_ff);
   assign done   = done_ff;

endmodule

// ===== hw/rtl/lsie_accum.sv =====
// neighbor classification and energy accumulator
module lsie_accum #(
   parameter int unsigned SPIN_BITS = lsie_pkg::DEF_SPIN_BITS
) (
   input  logic                                 clock,
   input  lsie_pkg::acc_ctl_type                ctl,
   input  logic [SPIN_BITS-1:0]                 spin,
   input  logic [lsie_pkg::E_BITS-1:0]          hetero_energy,
   input  logic [lsie_pkg::E_BITS-1:0]          boundary_energy,
   output logic [lsie_pkg::ENERGY_BITS-1:0]     site_energy
);
   import lsie_pkg::*;

   logic [SPIN_BITS-1:0]   center_ff;
   logic [ENERGY_BITS-1:0] sum_ff;
   logic                   c_liquid, c_solid, n_liquid, n_solid;
   logic [E_BITS-1:0]      add_val;

   always_comb begin
      c_liquid = center_ff[SPIN_BITS-1];
      c_solid  = !center_ff[SPIN_BITS-1] && (center_ff != '0);
      n_liquid = spin[SPIN_BITS-1];
      n_solid  = !spin[SPIN_BITS-1] && (spin != '0);
      add_val  = '0;
      if ((c_liquid && n_solid) || (c_solid && n_liquid)) begin
         add_val = hetero_energy;
      end else if (c_solid && n_solid && (center_ff != spin)) begin
         add_val = boundary_energy;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         sum_ff <= '0;
      end else if (ctl.add) begin
         sum_ff <= sum_ff + ENERGY_BITS'(add_val);
      end
      if (ctl.load_center) begin
         center_ff <= spin;
      end
   end

   assign site_energy = sum_ff;

endmodule

// ===== hw/rtl/lattice_site_interface_energy.sv =====
// top level: spin lattice memory, sequencer and result register
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+----------------------------------------
//  req      | in  | req_tvalid/tready    | tdata: pos_x, pos_y, spin_value; tuser: opcode
//  rsp      | out | rsp_tvalid/tready    | tdata: site_energy; tuser: was_query
//  csr      | in  | csr_valid/csr_ready  | csr_index, csr_data
//
// a write passes through 6 reduction steps, dispatch, memory write and result load; a query
// through 6 reduction steps, dispatch, 9 reads through the single lattice port, a wait for
// the registered read data and result load; req_tready rises at the edge loading the result.
// reset clears control, loads default configuration; lattice stays undefined until written.
// a stalled result holds in the output register; the next transaction may be accepted
// and processed meanwhile, waiting in its result cycle until the held result is taken.
module lattice_site_interface_energy #(
   parameter int unsigned MAX_WIDTH  = lsie_pkg::DEF_MAX_WIDTH,
   parameter int unsigned MAX_HEIGHT = lsie_pkg::DEF_MAX_HEIGHT,
   parameter int unsigned SPIN_BITS  = lsie_pkg::DEF_SPIN_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [5:0] pos_x, [11:6] pos_y, [27:12] spin_value
   input  logic [0:0]  req_tuser,   // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [18:0] site_energy
   output logic [0:0]  rsp_tuser,   // [0] was_query
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import lsie_pkg::*;

   localparam int unsigned WW    = $clog2(MAX_WIDTH+1);
   localparam int unsigned HW    = $clog2(MAX_HEIGHT+1);
   localparam int unsigned XW    = $clog2(MAX_WIDTH);
   localparam int unsigned YW    = $clog2(MAX_HEIGHT);
   localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int unsigned AW    = $clog2(DEPTH);
   localparam logic [3:0]  LAST_SLOT = 4'(NBR_COUNT);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_WRITE,
      ST_READ,
      ST_FINISH
   } state_type;

   state_type              state_ff;
   logic [WW-1:0]          dim_w_ff;
   logic [HW-1:0]          dim_h_ff;
   logic [E_BITS-1:0]      hetero_ff;
   logic [E_BITS-1:0]      boundary_ff;
   logic                   op_ff;
   logic [SPIN_BITS-1:0]   spin_ff;
   logic [3:0]             slot_ff;
   logic                   rsp_valid_ff;
   logic [ENERGY_BITS-1:0] rsp_energy_ff;
   logic                   rsp_query_ff;

   logic [SPIN_BITS-1:0]   lattice_mem [DEPTH];
   logic [SPIN_BITS-1:0]   rd_data_ff;

   logic                   req_fire;
   logic                   coord_done;
   logic [XW-1:0]          site_x;
   logic [YW-1:0]          site_y;
   logic [XW-1:0]          x_dec, x_inc, x_sel;
   logic [YW-1:0]          y_dec, y_inc, y_sel;
   nbr_sel_type            sel;
   logic [AW-1:0]          mem_addr;
   logic                   mem_we;
   acc_ctl_type            acc_ctl;
   logic [ENERGY_BITS-1:0] acc_sum;
   logic                   out_free;
   logic                   rsp_load;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_load   = (state_ff == ST_FINISH) && out_free;

   lsie_coord #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_coord (
      .clock  (clock),
      .reset  (reset),
      .start  (req_fire),
      .pos_x  (req_tdata[5:0]),
      .pos_y  (req_tdata[11:6]),
      .dim_w  (dim_w_ff),
      .dim_h  (dim_h_ff),
      .site_x (site_x),
      .site_y (site_y),
      .done   (coord_done)
   );

   // torus neighbors and the address of the current read slot or of the write site
   always_comb begin
      x_dec = (site_x == '0) ? XW'(dim_w_ff - WW'(1)) : site_x - XW'(1);
      x_inc = ((WW+1)'(site_x) + (WW+1)'(1) >= (WW+1)'(dim_w_ff)) ? '0 : site_x + XW'(1);
      y_dec = (site_y == '0) ? YW'(dim_h_ff - HW'(1)) : site_y - YW'(1);
      y_inc = ((HW+1)'(site_y) + (HW+1)'(1) >= (HW+1)'(dim_h_ff)) ? '0 : site_y + YW'(1);
      sel   = nbr_sel(slot_ff);
      case (sel.xs)
         AX_DEC:  x_sel = x_dec;
         AX_INC:  x_sel = x_inc;
         default: x_sel = site_x;
      endcase
      case (sel.ys)
         AX_DEC:  y_sel = y_dec;
         AX_INC:  y_sel = y_inc;
         default: y_sel = site_y;
      endcase
      if (state_ff == ST_WRITE) begin
         mem_addr = AW'(site_y) * AW'(MAX_WIDTH) + AW'(site_x);
      end else begin
         mem_addr = AW'(y_sel) * AW'(MAX_WIDTH) + AW'(x_sel);
      end
      mem_we = (state_ff == ST_WRITE);
   end

   // data of slot n arrives while slot n+1 is addressed
   always_comb begin
      acc_ctl.clear       = (state_ff == ST_REDUCE);
      acc_ctl.load_center = (state_ff == ST_READ) && (slot_ff == 4'd1);
      acc_ctl.add         = (state_ff == ST_READ) && (slot_ff > 4'd1);
   end

   lsie_accum #(
      .SPIN_BITS (SPIN_BITS)
   ) u_accum (
      .clock           (clock),
      .ctl             (acc_ctl),
      .spin            (rd_data_ff),
      .hetero_energy   (hetero_ff),
      .boundary_energy (boundary_ff),
      .site_energy     (acc_sum)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         lattice_mem[mem_addr] <= spin_ff;
      end
      rd_data_ff <= lattice_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_w_ff    <= WW'(clamp_dim(RST_DIM, MAX_WIDTH));
         dim_h_ff    <= HW'(clamp_dim(RST_DIM, MAX_HEIGHT));
         hetero_ff   <= RST_ENERGY;
         boundary_ff <= RST_ENERGY;
      end else if (csr_valid && csr_ready) begin
         case (csr_reg_type'(csr_index))
            REG_WIDTH:    dim_w_ff    <= WW'(clamp_dim(csr_data[DIM_BITS-1:0], MAX_WIDTH));
            REG_HEIGHT:   dim_h_ff    <= HW'(clamp_dim(csr_data[DIM_BITS-1:0], MAX_HEIGHT));
            REG_HETERO:   hetero_ff   <= csr_data;
            REG_BOUNDARY: boundary_ff <= csr_data;
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         op_ff        <= OP_WRITE;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  op_ff    <= req_tuser[0];
                  spin_ff  <= SPIN_BITS'($signed(req_tdata[27:12]));
                  state_ff <= ST_REDUCE;
               end
            end
            ST_REDUCE: begin
               slot_ff <= '0;
               if (coord_done) begin
                  state_ff <= (op_ff == OP_QUERY) ? ST_READ : ST_WRITE;
               end
            end
            ST_WRITE: begin
               state_ff <= ST_FINISH;
            end
            ST_READ: begin
               slot_ff <= slot_ff + 4'd1;
               if (slot_ff == LAST_SLOT + 4'd1) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_query_ff  <= op_ff;
                  rsp_energy_ff <= (op_ff == OP_QUERY) ? acc_sum : '0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_energy_ff};
   assign rsp_tuser  = rsp_query_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("block ready right after accepting a transaction");

   a_write_ack_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0] == OP_WRITE) |-> (rsp_tdata == '0))
      else $error("write acknowledge carries nonzero energy");

   a_coord_done_in_reduce: assert property (@(posedge clock) disable iff (reset)
      coord_done |-> (state_ff == ST_REDUCE))
      else $error("coordinate reduction finished outside the reduce phase");

   a_read_slot_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ && slot_ff == LAST_SLOT + 4'd1) |=> (state_ff == ST_FINISH))
      else $error("neighbor read sequence overran");

endmodule

// ===== test/tb.sv =====
// testbench for the lattice site interface energy block: predictor, stimulus and result checks
`timescale 1ns / 1ps

module tb;
   import lsie_pkg::*;

   localparam int MAX_SIDE        = DEF_MAX_WIDTH;
   localparam int STUCK_LIMIT     = 4000;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int ITEM_TARGET     = 1300;

   typedef struct packed {
      logic [ENERGY_BITS-1:0] energy;
      logic                   was_query;
   } site_outcome_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [5:0] pos_x, [11:6] pos_y, [27:12] spin_value
   logic [0:0]  req_tuser;   // [0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // [18:0] site_energy
   logic [0:0]  rsp_tuser;   // [0] was_query
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   // predictor state
   logic [DIM_BITS-1:0] cfg_width;
   logic [DIM_BITS-1:0] cfg_height;
   logic [E_BITS-1:0]   cfg_hetero;
   logic [E_BITS-1:0]   cfg_boundary;
   logic signed [15:0]  spin_copy [0:MAX_SIDE*MAX_SIDE-1];
   bit                  site_written [0:MAX_SIDE*MAX_SIDE-1];
   site_outcome_type    awaited_results [$];

   int mismatches;
   int items_sent;
   int stuck_cycles;
   bit req_idle_en;
   bit rsp_idle_en;
   bit hold_req;

   lattice_site_interface_energy uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic int active_extent(input logic [DIM_BITS-1:0] v);
      if (v == 0)
         return 1;
      if (v > MAX_SIDE)
         return MAX_SIDE;
      return int'(v);
   endfunction

   function automatic logic [ENERGY_BITS-1:0] predict_site_energy(input int xc, input int yc);
      int w, h, xn, yn, total;
      logic signed [15:0] c, n;
      w = active_extent(cfg_width);
      h = active_extent(cfg_height);
      total = 0;
      c = spin_copy[yc * MAX_SIDE + xc];
      for (int dy = -1; dy <= 1; dy++) begin
         for (int dx = -1; dx <= 1; dx++) begin
            if (dx == 0 && dy == 0)
               continue;
            xn = (xc + w + dx) % w;
            yn = (yc + h + dy) % h;
            n = spin_copy[yn * MAX_SIDE + xn];
            // zero spin is neither liquid nor solid
            if ((c < 0 && n > 0) || (c > 0 && n < 0))
               total += cfg_hetero;
            else if (c > 0 && n > 0 && c != n)
               total += cfg_boundary;
         end
      end
      return total[ENERGY_BITS-1:0];
   endfunction

   function automatic logic [15:0] pick_spin();
      case ($urandom_range(5))
         0:       return 16'h0000;
         1:       return 16'(0 - $urandom_range(1, 4));
         2:       return 16'($urandom_range(1, 3));
         3:       return 16'($urandom);
         4:       return $urandom_range(1) ? 16'h8000 : 16'h7fff;
         default: return 16'($urandom_range(1, 8));
      endcase
   endfunction

   function automatic int pick_energy();
      case ($urandom_range(3))
         0:       return 0;
         1:       return 65535;
         2:       return 256;
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned want,
                                  input longint unsigned got);
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
      mismatches++;
   endtask

   // starts and ends at a falling edge; tvalid stays high for a back-to-back transaction
   task automatic send_item(input opcode_type op, input logic [5:0] x, input logic [5:0] y,
                            input logic [15:0] spin);
      int w, h, xr, yr;
      site_outcome_type outcome;
      if (req_idle_en && $urandom_range(99) < 28) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, ($urandom_range(9) == 0) ? 20 : 3)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, spin, y, x};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      w = active_extent(cfg_width);
      h = active_extent(cfg_height);
      xr = x % w;
      yr = y % h;
      if (op == OP_WRITE) begin
         spin_copy[yr * MAX_SIDE + xr] = spin;
         site_written[yr * MAX_SIDE + xr] = 1'b1;
         outcome = '{energy: '0, was_query: 1'b0};
      end else begin
         outcome = '{energy: predict_site_energy(xr, yr), was_query: 1'b1};
      end
      awaited_results.push_back(outcome);
      items_sent++;
      @(negedge clock);
   endtask

   // fills any unwritten site of the neighborhood first, so no undefined entry is read
   task automatic query_site(input logic [5:0] x, input logic [5:0] y);
      int w, h, xr, yr, xn, yn;
      w = active_extent(cfg_width);
      h = active_extent(cfg_height);
      xr = x % w;
      yr = y % h;
      for (int dy = -1; dy <= 1; dy++) begin
         for (int dx = -1; dx <= 1; dx++) begin
            xn = (xr + w + dx) % w;
            yn = (yr + h + dy) % h;
            if (!site_written[yn * MAX_SIDE + xn])
               send_item(OP_WRITE, 6'(xn), 6'(yn), pick_spin());
         end
      end
      send_item(OP_QUERY, x, y, 16'($urandom));
   endtask

   task automatic wait_until_idle();
      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input csr_reg_type idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_WIDTH:    cfg_width    = data[DIM_BITS-1:0];
         REG_HEIGHT:   cfg_height   = data[DIM_BITS-1:0];
         REG_HETERO:   cfg_hetero   = data;
         REG_BOUNDARY: cfg_boundary = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_lattice(input int wdim, input int hdim, input int he, input int be);
      logic [15:0] dim_word;
      wait_until_idle();
      // upper data bits are junk for the dimension registers
      dim_word = 16'($urandom);
      dim_word[DIM_BITS-1:0] = wdim[DIM_BITS-1:0];
      write_csr(REG_WIDTH, dim_word);
      dim_word = 16'($urandom);
      dim_word[DIM_BITS-1:0] = hdim[DIM_BITS-1:0];
      write_csr(REG_HEIGHT, dim_word);
      write_csr(REG_HETERO, he[15:0]);
      write_csr(REG_BOUNDARY, be[15:0]);
   endtask

   task automatic test_directed_neighborhood();
      // centre at the origin of the full lattice: neighbors on the low side wrap across an edge
      send_item(OP_WRITE, 6'd0,  6'd0,  16'd5);
      send_item(OP_WRITE, 6'd63, 6'd63, 16'h8000);
      send_item(OP_WRITE, 6'd0,  6'd63, 16'h7fff);
      send_item(OP_WRITE, 6'd1,  6'd63, 16'd5);
      send_item(OP_WRITE, 6'd63, 6'd0,  16'h0000);
      send_item(OP_WRITE, 6'd1,  6'd0,  16'hffff);
      send_item(OP_WRITE, 6'd63, 6'd1,  16'd1);
      send_item(OP_WRITE, 6'd0,  6'd1,  16'd5);
      send_item(OP_WRITE, 6'd1,  6'd1,  16'h7fff);
      send_item(OP_QUERY, 6'd0,  6'd0,  16'hffff);
      // liquid centre, then a zero centre
      send_item(OP_WRITE, 6'd0,  6'd0,  16'hffff);
      send_item(OP_QUERY, 6'd0,  6'd0,  16'h0000);
      send_item(OP_WRITE, 6'd0,  6'd0,  16'h0000);
      send_item(OP_QUERY, 6'd0,  6'd0,  16'h5a5a);
      query_site(6'd63, 6'd63);
      query_site(6'd1, 6'd1);
   endtask

   task automatic test_tiny_lattices();
      // single site: all eight neighbors are the centre itself
      set_lattice(1, 1, 65535, 65535);
      send_item(OP_WRITE, 6'($urandom), 6'($urandom), pick_spin());
      query_site(6'($urandom), 6'($urandom));
      query_site(6'd63, 6'd63);
      // 2x2 with one solid among liquids gives the largest possible sum
      set_lattice(2, 2, 65535, 0);
      send_item(OP_WRITE, 6'd0, 6'd0, 16'd5);
      send_item(OP_WRITE, 6'd1, 6'd0, 16'hfffd);
      send_item(OP_WRITE, 6'd0, 6'd1, 16'hfffd);
      send_item(OP_WRITE, 6'd1, 6'd1, 16'hfffd);
      send_item(OP_QUERY, 6'd0, 6'd0, 16'h0000);
      send_item(OP_QUERY, 6'd3, 6'd5, 16'hffff);
      set_lattice(2, 2, 0, 65535);
      send_item(OP_WRITE, 6'd1, 6'd0, 16'd6);
      send_item(OP_WRITE, 6'd0, 6'd1, 16'd7);
      send_item(OP_WRITE, 6'd1, 6'd1, 16'd5);
      send_item(OP_QUERY, 6'd62, 6'd62, 16'h0000);
      // zero dimension reads as one, oversize saturates
      set_lattice(0, 127, pick_energy(), pick_energy());
      repeat (3) query_site(6'($urandom), 6'($urandom));
      set_lattice(127, 0, pick_energy(), pick_energy());
      repeat (3) query_site(6'($urandom), 6'($urandom));
      set_lattice(2, 1, pick_energy(), pick_energy());
      repeat (3) query_site(6'($urandom), 6'($urandom));
      set_lattice(1, 2, pick_energy(), pick_energy());
      repeat (3) query_site(6'($urandom), 6'($urandom));
   endtask

   task automatic test_output_backpressure();
      set_lattice(5, 4, pick_energy(), pick_energy());
      hold_req = 1'b1;
      repeat (24) begin
         if ($urandom_range(1))
            send_item(OP_WRITE, 6'($urandom), 6'($urandom), pick_spin());
         else
            query_site(6'($urandom), 6'($urandom));
      end
      wait_until_idle();
   endtask

   task automatic test_random_traffic(input int target);
      int phase, wdim, hdim;
      phase = 0;
      while (items_sent < target) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: begin
               wdim = $urandom_range(1, 6);
               hdim = $urandom_range(1, 6);
            end
            6, 7: begin
               wdim = $urandom_range(3, 16);
               hdim = $urandom_range(3, 16);
            end
            8: begin
               wdim = ($urandom_range(2) == 0) ? 0 : ($urandom_range(1) ? 64 : 127);
               hdim = $urandom_range(0, 8);
            end
            default: begin
               wdim = $urandom_range(17, 64);
               hdim = $urandom_range(17, 64);
            end
         endcase
         set_lattice(wdim, hdim, pick_energy(), pick_energy());
         // one long stretch with no idling on either side
         req_idle_en = (phase != 3);
         rsp_idle_en = (phase != 3);
         repeat ($urandom_range(30, 70)) begin
            if (items_sent >= target)
               break;
            if ($urandom_range(99) < 35)
               send_item(OP_WRITE, 6'($urandom), 6'($urandom), pick_spin());
            else
               query_site(6'($urandom), 6'($urandom));
         end
         phase++;
      end
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
   endtask

   // receiver: random stalls plus one long hold-off counted here
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end
         rsp_tready <= !rsp_idle_en || ($urandom_range(99) >= 28);
      end
   end

   always @(posedge clock) begin
      site_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_results.size() == 0) begin
            report_mismatch("transaction with nothing expected", 0, rsp_tdata[ENERGY_BITS-1:0]);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_tdata[ENERGY_BITS-1:0] !== want.energy)
               report_mismatch("site_energy", want.energy, rsp_tdata[ENERGY_BITS-1:0]);
            if (rsp_tuser[0] !== want.was_query)
               report_mismatch("was_query", want.was_query, rsp_tuser[0]);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("lattice_site_interface_energy test failed");
            $finish;
         end
      end
   end

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      mismatches   = 0;
      items_sent   = 0;
      stuck_cycles = 0;
      req_idle_en  = 1'b1;
      rsp_idle_en  = 1'b1;
      hold_req     = 1'b0;
      cfg_width    = RST_DIM;
      cfg_height   = RST_DIM;
      cfg_hetero   = RST_ENERGY;
      cfg_boundary = RST_ENERGY;
      for (int i = 0; i < MAX_SIDE * MAX_SIDE; i++) begin
         spin_copy[i]    = '0;
         site_written[i] = 1'b0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_neighborhood();
      test_tiny_lattices();
      test_output_backpressure();
      test_random_traffic(ITEM_TARGET);

      wait_until_idle();
      repeat (30) @(posedge clock);
      if (mismatches == 0)
         $display("lattice_site_interface_energy test passed");
      else
         $display("lattice_site_interface_energy test failed");
      $finish;
   end

endmodule
